/* sv/timestamped_history_with_subscribers_unit_assert.svh */
`ifndef TIMESTAMPED_HISTORY_WITH_SUBSCRIBERS_UNIT_ASSERT_SVH
`define TIMESTAMPED_HISTORY_WITH_SUBSCRIBERS_UNIT_ASSERT_SVH

// same-cycle implication
`define TSHS_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tshs assertion failed");

// next-cycle implication
`define TSHS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tshs assertion failed");

`endif

/* sv/tshs_pkg.sv */
`timescale 1ns / 1ps

package tshs_pkg;

    localparam int SLOTS    = 8;
    localparam int MAX_SUBS = 8;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int SLOTC_W  = $clog2(SLOTS + 1);
    localparam int SUB_W    = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
    localparam int SUBC_W   = $clog2(MAX_SUBS + 1);
    localparam int DIV_W    = 32;
    localparam int DCNT_W   = $clog2(DIV_W);

    localparam logic [SLOTC_W-1:0] SLOTS_N    = SLOTC_W'(SLOTS);
    localparam logic [SUBC_W-1:0]  MAX_SUBS_N = SUBC_W'(MAX_SUBS);

    localparam logic [31:0] PERIOD_RST = 32'd1;
    localparam logic [15:0] MAXLEN_RST = 16'hFFFF;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_MAXLEN = 2'd1;
    localparam logic [1:0] REG_ENABLE = 2'd2;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_QUERY = 2'd1,
        OP_SUB   = 2'd2,
        OP_UNSUB = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        K_NOTIFY = 2'd0,
        K_QUERY  = 2'd1,
        K_SUB    = 2'd2,
        K_UNSUB  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_TOO_NEW    = 3'd2,
        ST_TOO_OLD    = 3'd3,
        ST_NOT_FILLED = 3'd4,
        ST_TABLE_FULL = 3'd5,
        ST_DISABLED   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P_CHK,
        S_P_LOOP,
        S_P_WAIT,
        S_P_EMIT,
        S_Q_START,
        S_Q_NEW,
        S_Q_OLD,
        S_Q_WALK,
        S_Q_OUT,
        S_S_START,
        S_S_DIV,
        S_S_MUL,
        S_S_OUT,
        S_U_LOOP,
        S_U_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] period_time;
        logic [15:0] max_length;
        logic        module_enabled;
    } cfg_t;

    typedef struct packed {
        logic  load;
        logic  put_store;
        logic  div_start_mod;
        logic  div_start_per;
        logic  mask_set;
        logic  q_init;
        logic  q_newest;
        logic  q_check;
        logic  q_walk;
        logic  sub_start;
        logic  sub_div_take;
        logic  sub_commit;
        logic  un_step;
        logic  emit;
        kind_t emit_kind;
    } cmd_t;

    typedef struct packed {
        logic put_bad;
        logic loop_end;
        logic div_busy;
        logic div_done;
        logic mask_zero;
        logic q_direct;
        logic q_range_bad;
        logic q_walk_end;
        logic enabled;
        logic sub_trivial;
        logic out_free;
    } st_t;

    function automatic logic [2:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+2:0] ext;
        ext = {3'b000, idx};
        return ext[2:0];
    endfunction

endpackage

/* sv/tshs_div.sv */
`timescale 1ns / 1ps

module tshs_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tshs_pkg::DIV_W-1:0] dividend,
    input  logic [tshs_pkg::DIV_W-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [tshs_pkg::DIV_W-1:0] quotient,
    output logic [tshs_pkg::DIV_W-1:0] remainder
);
    import tshs_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_W:0]    trial;

    assign trial = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* sv/tshs_ctrl.sv */
`timescale 1ns / 1ps
`include "timestamped_history_with_subscribers_unit_assert.svh"

module tshs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  tshs_pkg::op_t  op,
    input  tshs_pkg::st_t  st,
    output logic           s_tready,
    output tshs_pkg::cmd_t cmd
);
    import tshs_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (op)
                        OP_PUT:   state_next = S_P_CHK;
                        OP_QUERY: state_next = S_Q_START;
                        OP_SUB:   state_next = S_S_START;
                        OP_UNSUB: state_next = S_U_LOOP;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_P_CHK:   state_next = st.put_bad ? S_IDLE : S_P_LOOP;
            S_P_LOOP:  state_next = st.loop_end ? S_P_EMIT : S_P_WAIT;
            S_P_WAIT:
            begin
                if (st.div_done)
                    state_next = S_P_LOOP;
            end
            S_P_EMIT:
            begin
                if (st.mask_zero)
                    state_next = S_IDLE;
            end
            S_Q_START: state_next = st.q_direct ? S_Q_OUT : S_Q_NEW;
            S_Q_NEW:   state_next = S_Q_OLD;
            S_Q_OLD:   state_next = st.q_range_bad ? S_Q_OUT : S_Q_WALK;
            S_Q_WALK:
            begin
                if (st.q_walk_end)
                    state_next = S_Q_OUT;
            end
            S_Q_OUT:
            begin
                if (st.out_free)
                    state_next = S_IDLE;
            end
            S_S_START:
            begin
                priority if (!st.enabled)
                    state_next = S_S_OUT;
                else if (st.sub_trivial)
                    state_next = S_S_MUL;
                else
                    state_next = S_S_DIV;
            end
            S_S_DIV:
            begin
                if (st.div_done)
                    state_next = S_S_MUL;
            end
            S_S_MUL:   state_next = S_S_OUT;
            S_S_OUT:
            begin
                if (st.out_free)
                    state_next = S_IDLE;
            end
            S_U_LOOP:
            begin
                if (st.loop_end)
                    state_next = S_U_OUT;
            end
            S_U_OUT:
            begin
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.emit_kind = K_NOTIFY;
        s_tready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_P_CHK:   cmd.put_store = !st.put_bad;
            S_P_LOOP:  cmd.div_start_mod = !st.loop_end && !st.div_busy;
            S_P_WAIT:  cmd.mask_set = st.div_done;
            S_P_EMIT:
            begin
                cmd.emit      = !st.mask_zero && st.out_free;
                cmd.emit_kind = K_NOTIFY;
            end
            S_Q_START: cmd.q_init = 1'b1;
            S_Q_NEW:   cmd.q_newest = 1'b1;
            S_Q_OLD:   cmd.q_check = 1'b1;
            S_Q_WALK:  cmd.q_walk = 1'b1;
            S_Q_OUT:
            begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = K_QUERY;
            end
            S_S_START:
            begin
                cmd.sub_start     = 1'b1;
                cmd.div_start_per = st.enabled && !st.sub_trivial && !st.div_busy;
            end
            S_S_DIV:   cmd.sub_div_take = st.div_done;
            S_S_MUL:   cmd.sub_commit = 1'b1;
            S_S_OUT:
            begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = K_SUB;
            end
            S_U_LOOP:  cmd.un_step = 1'b1;
            S_U_OUT:
            begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = K_UNSUB;
            end
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `TSHS_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, st.out_free)
    `TSHS_ASSERT_NEXT(a_leave_idle, clk, rst_n, s_tvalid && s_tready, state_reg != S_IDLE)
    `TSHS_ASSERT_IMP(a_div_idle, clk, rst_n, cmd.div_start_mod || cmd.div_start_per, !st.div_busy)

endmodule

/* sv/tshs_dp.sv */
`timescale 1ns / 1ps

module tshs_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [143:0]   s_tdata,
    input  tshs_pkg::cfg_t cfg,
    input  tshs_pkg::cmd_t cmd,
    output tshs_pkg::st_t  st,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [87:0]    m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast
);
    import tshs_pkg::*;

    logic [31:0]       rec_reg, rt_reg, la_reg, rp_reg;
    logic [15:0]       len_reg;

    logic [31:0]       slot_time_reg [SLOTS];
    logic [15:0]       slot_len_reg  [SLOTS];
    logic [SLOT_W-1:0] newest_reg;
    logic [31:0]       pc_reg;
    logic [31:0]       sub_addr_reg  [MAX_SUBS];
    logic [31:0]       sub_div_reg   [MAX_SUBS];
    logic [SUBC_W-1:0] sub_count_reg;

    logic [SUBC_W-1:0] sidx_reg, widx_reg;
    logic [MAX_SUBS-1:0] mask_reg;
    logic [SLOT_W-1:0] best_reg, ptr_reg;
    logic [SLOTC_W-1:0] n_reg;
    logic [31:0]       mindiff_reg, ntime_reg, divq_reg, granted_reg;
    status_t           stat_reg;
    logic              found_reg;
    logic [SUB_W-1:0]  fidx_reg;

    logic              out_valid_reg;
    kind_t             o_kind_reg;
    status_t           o_status_reg;
    logic [2:0]        o_slot_reg;
    logic [15:0]       o_len_reg;
    logic [31:0]       o_dest_reg, o_gp_reg;
    logic              o_last_reg;

    logic [SLOT_W-1:0] nidx, oldest, slot_raddr, ptr_inc;
    logic [SLOT_W:0]   old_sum;
    logic [31:0]       pc_inc, pc_new, slot_tq, diff, sub_rd_addr, sub_rd_div, sub_d;
    logic [33:0]       lim;
    logic              too_new, too_old;
    logic [SUB_W-1:0]  sub_raddr, pe_idx, found_idx, wr_idx;
    logic [MAX_SUBS-1:0] match, mask_rest;
    logic              div_busy, div_done;
    logic [31:0]       div_a, div_b, div_q, div_r, prod;
    logic              sub_full;

    tshs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start_mod || cmd.div_start_per),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign nidx    = (newest_reg == SLOT_W'(SLOTS - 1)) ? '0 : newest_reg + 1'b1;
    assign pc_inc  = pc_reg + 32'd1;
    assign pc_new  = (pc_inc == 32'd0) ? 32'd1 : pc_inc;
    assign old_sum = {1'b0, newest_reg} + (SLOT_W + 1)'(2);
    always_comb
    begin
        if ((32'(newest_reg) == pc_reg) && (pc_reg < 32'(SLOTS - 1)))
            oldest = SLOT_W'(1);
        else if (old_sum >= (SLOT_W + 1)'(SLOTS))
            oldest = SLOT_W'(old_sum - (SLOT_W + 1)'(SLOTS));
        else
            oldest = old_sum[SLOT_W-1:0];
    end
    assign ptr_inc = (ptr_reg == SLOT_W'(SLOTS - 1)) ? '0 : ptr_reg + 1'b1;

    assign slot_raddr = cmd.q_newest ? newest_reg : ptr_reg;
    assign slot_tq    = slot_time_reg[slot_raddr];
    assign diff       = (slot_tq >= rt_reg) ? slot_tq - rt_reg : rt_reg - slot_tq;
    assign lim        = {2'b00, ntime_reg} + {1'b0, cfg.period_time, 1'b0};
    assign too_new    = {2'b00, rt_reg} > lim;
    assign too_old    = rt_reg < slot_tq;

    always_comb
    begin
        pe_idx = '0;
        for (int i = MAX_SUBS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                pe_idx = SUB_W'(i);
        end
    end
    assign mask_rest = mask_reg & (mask_reg - 1'b1);

    assign sub_raddr   = cmd.emit ? pe_idx : sidx_reg[SUB_W-1:0];
    assign sub_rd_addr = sub_addr_reg[sub_raddr];
    assign sub_rd_div  = sub_div_reg[sub_raddr];
    assign sub_d       = (sub_rd_div == 32'd0) ? 32'd1 : sub_rd_div;

    always_comb
    begin
        found_idx = '0;
        for (int i = MAX_SUBS - 1; i >= 0; i--)
        begin
            match[i] = (SUBC_W'(i) < sub_count_reg) && (sub_addr_reg[i] == la_reg);
            if (match[i])
                found_idx = SUB_W'(i);
        end
    end

    assign div_a    = cmd.div_start_per ? rp_reg : pc_reg;
    assign div_b    = cmd.div_start_per ? cfg.period_time : sub_d;
    assign prod     = divq_reg * cfg.period_time;
    assign sub_full = !found_reg && (sub_count_reg >= MAX_SUBS_N);
    assign wr_idx   = cmd.un_step ? widx_reg[SUB_W-1:0]
                    : (found_reg ? fidx_reg : sub_count_reg[SUB_W-1:0]);

    always_comb
    begin
        st.put_bad     = len_reg > cfg.max_length;
        st.loop_end    = sidx_reg >= sub_count_reg;
        st.div_busy    = div_busy;
        st.div_done    = div_done;
        st.mask_zero   = (mask_reg == '0);
        st.q_direct    = !cfg.module_enabled || (pc_reg == 32'd0) || (rt_reg == 32'd0);
        st.q_range_bad = too_new || too_old;
        st.q_walk_end  = (n_reg == '0) || (diff > mindiff_reg);
        st.enabled     = cfg.module_enabled;
        st.sub_trivial = (rp_reg == 32'd0) || (rp_reg < cfg.period_time)
                       || (cfg.period_time == 32'd0);
        st.out_free    = !out_valid_reg || m_tready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rec_reg <= s_tdata[31:0];
            len_reg <= s_tdata[47:32];
            rt_reg  <= s_tdata[79:48];
            la_reg  <= s_tdata[111:80];
            rp_reg  <= s_tdata[143:112];
        end
        if (cmd.q_init)
        begin
            best_reg    <= newest_reg;
            ptr_reg     <= oldest;
            mindiff_reg <= '1;
            n_reg       <= (pc_reg > 32'(SLOTS)) ? SLOTS_N : pc_reg[SLOTC_W-1:0];
        end
        if (cmd.q_newest)
            ntime_reg <= slot_tq;
        if (cmd.q_walk && !st.q_walk_end)
        begin
            mindiff_reg <= diff;
            best_reg    <= ptr_reg;
            ptr_reg     <= ptr_inc;
            n_reg       <= n_reg - 1'b1;
        end
        if (cmd.sub_start)
        begin
            found_reg <= |match;
            fidx_reg  <= found_idx;
            divq_reg  <= 32'd1;
        end
        if (cmd.sub_div_take)
            divq_reg <= div_q;
        if (cmd.sub_commit)
            granted_reg <= (la_reg == 32'd0) ? cfg.period_time : prod;
        if ((cmd.sub_commit && !sub_full)
            || (cmd.un_step && !st.loop_end && (sub_rd_addr != la_reg)))
        begin
            sub_addr_reg[wr_idx] <= cmd.un_step ? sub_rd_addr : la_reg;
            sub_div_reg[wr_idx]  <= cmd.un_step ? sub_rd_div : divq_reg;
        end
        if (cmd.emit)
        begin
            o_kind_reg   <= cmd.emit_kind;
            o_status_reg <= ST_OK;
            o_slot_reg   <= '0;
            o_len_reg    <= '0;
            o_dest_reg   <= '0;
            o_gp_reg     <= '0;
            o_last_reg   <= 1'b1;
            unique case (cmd.emit_kind)
                K_NOTIFY:
                begin
                    o_slot_reg <= slot_field(newest_reg);
                    o_len_reg  <= len_reg;
                    o_dest_reg <= sub_rd_addr;
                    o_last_reg <= (mask_rest == '0);
                end
                K_QUERY:
                begin
                    o_status_reg <= stat_reg;
                    if (stat_reg == ST_OK)
                    begin
                        o_slot_reg <= slot_field(best_reg);
                        o_len_reg  <= slot_len_reg[best_reg];
                    end
                end
                K_SUB:
                begin
                    o_status_reg <= stat_reg;
                    if (stat_reg == ST_OK)
                        o_gp_reg <= granted_reg;
                end
                K_UNSUB:  o_status_reg <= ST_OK;
                default:  o_status_reg <= ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_time_reg[i] <= '0;
                slot_len_reg[i]  <= '0;
            end
            newest_reg    <= '0;
            pc_reg        <= '0;
            sub_count_reg <= '0;
            sidx_reg      <= '0;
            widx_reg      <= '0;
            mask_reg      <= '0;
            stat_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                sidx_reg <= '0;
                widx_reg <= '0;
                mask_reg <= '0;
            end
            if (cmd.put_store)
            begin
                newest_reg          <= nidx;
                pc_reg              <= pc_new;
                slot_time_reg[nidx] <= rec_reg;
                slot_len_reg[nidx]  <= len_reg;
            end
            if (cmd.mask_set)
            begin
                mask_reg[sidx_reg[SUB_W-1:0]] <= (div_r == 32'd0);
                sidx_reg <= sidx_reg + 1'b1;
            end
            if (cmd.emit && (cmd.emit_kind == K_NOTIFY))
                mask_reg <= mask_rest;
            if (cmd.q_init)
            begin
                priority if (!cfg.module_enabled)
                    stat_reg <= ST_DISABLED;
                else if (pc_reg == 32'd0)
                    stat_reg <= ST_EMPTY;
                else
                    stat_reg <= ST_OK;
            end
            if (cmd.q_check)
            begin
                priority if (too_new)
                    stat_reg <= ST_TOO_NEW;
                else if (too_old)
                    stat_reg <= ST_TOO_OLD;
            end
            if (cmd.q_walk && st.q_walk_end && (ntime_reg == 32'd0))
                stat_reg <= ST_NOT_FILLED;
            if (cmd.sub_start)
                stat_reg <= cfg.module_enabled ? ST_OK : ST_DISABLED;
            if (cmd.sub_commit)
            begin
                if (sub_full)
                    stat_reg <= ST_TABLE_FULL;
                else if (!found_reg)
                    sub_count_reg <= sub_count_reg + 1'b1;
            end
            if (cmd.un_step)
            begin
                if (st.loop_end)
                    sub_count_reg <= widx_reg;
                else
                begin
                    sidx_reg <= sidx_reg + 1'b1;
                    if (sub_rd_addr != la_reg)
                        widx_reg <= widx_reg + 1'b1;
                end
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, o_gp_reg, o_dest_reg, o_len_reg, o_slot_reg, o_status_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

endmodule

/* sv/timestamped_history_with_subscribers_unit.sv */
// Timestamped history ring with a subscriber table.
// Input beats arrive on s_t*: s_tuser carries the operation (put, query,
// subscribe, unsubscribe), s_tdata the operands. Result beats leave on m_t*:
// m_tuser carries the result kind, m_tlast marks the final result of an item.
// Registers (period_time, max_length, module_enabled) sit on the APB port.
// One item is worked on at a time; s_tready is high only while idle.
// Put: checks the length and stores the record unless it is refused, then
// works out the count modulo for each subscriber in the shared radix-2
// divider, then sends one notify beat per subscriber whose modulo is zero.
// Query: a direct answer, a range refusal, or a ring walk, which reads
// one slot a cycle. Subscribe: a disabled answer, a direct commit, or a
// commit after a period divide when one is needed.
// Unsubscribe: walks the table one entry a cycle, at most MAX_SUBS entries.
// A result sits in the output register; while the receiver stalls the
// block holds it and waits before producing the next beat.
// Reset clears the ring, the put count, the subscriber count and the
// registers to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module timestamped_history_with_subscribers_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // record_time, data_length, request_time,
                                   // listener_addr, request_period
    input  logic [1:0]   s_tuser,  // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,  // status, slot, slot_length, dest_addr,
                                   // granted_period
    output logic [1:0]   m_tuser,  // kind
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tshs_pkg::*;

    logic [31:0] period_reg;
    logic [15:0] maxlen_reg;
    logic        enable_reg;
    logic        wr_en;
    cfg_t        cfg;
    cmd_t        cmd;
    st_t         st;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            maxlen_reg <= MAXLEN_RST;
            enable_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_PERIOD: period_reg <= pwdata;
                REG_MAXLEN: maxlen_reg <= pwdata[15:0];
                REG_ENABLE: enable_reg <= pwdata[0];
                default:    enable_reg <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PERIOD: prdata = period_reg;
            REG_MAXLEN: prdata = {16'h0000, maxlen_reg};
            REG_ENABLE: prdata = {31'd0, enable_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg.period_time    = period_reg;
    assign cfg.max_length     = maxlen_reg;
    assign cfg.module_enabled = enable_reg;

    tshs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (op_t'(s_tuser)),
        .st       (st),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    tshs_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
